@@ hdl/clrv_pkg.sv @@
// Shared constants, command codes and status types for the conditional
// log-return variance block. No dependencies; used by the divider, datapath, controller, top level and testbench.
package clrv_pkg;

  // Capacity of the return counter and fraction bits of the log value.
  localparam int MAX_RETURNS   = 4194304;
  localparam int LOG_FRAC_BITS = 24;

  // Derived widths.
  localparam int CNT_W    = $clog2(MAX_RETURNS + 1);
  localparam int MAG_W    = LOG_FRAC_BITS + 5;
  localparam int RMAG_W   = LOG_FRAC_BITS + 5;
  localparam int SQ_SHIFT = 2 * LOG_FRAC_BITS - 32;
  localparam int SQP_W    = 2 * RMAG_W + 1;
  localparam int IT_W     = $clog2(LOG_FRAC_BITS);
  localparam int LNP_W    = 48;
  localparam int SUM_W    = 52;
  localparam int SQS_W    = 64;
  localparam int VAR_W    = 41;
  localparam int USED_W   = 23;
  localparam int PRICE_W  = 32;
  localparam int HALF_W   = SUM_W / 2;
  localparam int MACC_W   = 2 * SUM_W;

  // ln(2) in Q0.28 and rounding offsets.
  localparam logic [27:0]        LN2_Q28   = 28'hB17217F;
  localparam logic [SQP_W-1:0]   SQ_HALF   = (SQP_W'(1) << SQ_SHIFT) >> 1;
  localparam logic [MACC_W-1:0]  MSQ_HALF  = (MACC_W'(1) << SQ_SHIFT) >> 1;
  localparam logic [VAR_W-1:0]   VAR_MAX   = '1;
  localparam logic [31:0]        THR_RESET = 32'd6553600;

  // Register addresses (byte address bit 2 selects the register word).
  localparam logic REG_THRESHOLD = 1'b0;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NORM,
    CMD_LOG,
    CMD_LN,
    CMD_SQ,
    CMD_ACC,
    CMD_DIV_MEAN,
    CMD_TAKE_MEAN,
    CMD_DIV_EX2,
    CMD_TAKE_EX2,
    CMD_MSQ_LO,
    CMD_MSQ_MID,
    CMD_MSQ_HI,
    CMD_MSQ_RND,
    CMD_EMIT
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic norm_done;
    logic last;
    logic count_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ hdl/clrv_in_if.sv @@
// Input channel of the variance block: one price sample per item.
// Depends on nothing.
interface clrv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic        path_start;
  logic        last_sample;

  modport source(output valid, price, path_start, last_sample, input ready);
  modport sink(input valid, price, path_start, last_sample, output ready);
endinterface

@@ hdl/clrv_out_if.sv @@
// Output channel of the variance block: one result item per data set.
// Depends on nothing.
interface clrv_out_if;
  logic        valid;
  logic        ready;
  logic [40:0] variance;
  logic [22:0] returns_used;
  logic        no_returns;
  logic        count_overflow;

  modport source(output valid, variance, returns_used, no_returns, count_overflow,
                 input ready);
  modport sink(input valid, variance, returns_used, no_returns, count_overflow,
               output ready);
endinterface

@@ hdl/clrv_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on clrv_pkg.
module clrv_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               dividend,
  input  logic [clrv_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [63:0]               quotient
);

  logic [63:0]                 q;
  logic [clrv_pkg::CNT_W-1:0]  rem;
  logic [clrv_pkg::CNT_W:0]    rem_sh;
  logic [5:0]                  cnt;
  logic                        busy;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh   = {rem, q[63]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= clrv_pkg::CNT_W'(rem_sh - {1'b0, divisor});
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= rem_sh[clrv_pkg::CNT_W-1:0];
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/clrv_dp.sv @@
// Datapath: fixed-point log, return square, accumulators, final variance
// and the output register. Depends on clrv_pkg and clrv_div.
module clrv_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  clrv_pkg::cmd_t        cmd,
  input  logic [31:0]           threshold,
  input  logic [31:0]           in_price,
  input  logic                  in_start,
  input  logic                  in_last,
  output clrv_pkg::status_t     status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [40:0]           out_variance,
  output logic [22:0]           out_used,
  output logic                  out_none,
  output logic                  out_ovf
);

  localparam int LFB = clrv_pkg::LOG_FRAC_BITS;
  localparam int CW  = clrv_pkg::CNT_W;
  localparam int HW  = clrv_pkg::HALF_W;
  localparam int MW  = clrv_pkg::MACC_W;

  // Item and log registers.
  logic [31:0]                        m;
  logic [4:0]                         k;
  logic [LFB-1:0]                     frac;
  logic                               start_l, last_l;
  logic [31:0]                        price_l;
  logic signed [clrv_pkg::LNP_W-1:0]  lnp, prev_log, r_reg;
  logic [31:0]                        prev_price;
  logic                               prev_present;
  logic                               qual;
  logic [63:0]                        sq_reg;

  // Accumulators.
  logic [CW-1:0]                      count;
  logic signed [clrv_pkg::SUM_W-1:0]  rsum;
  logic [63:0]                        sqsum;
  logic                               ovf;

  // Final arithmetic.
  logic [clrv_pkg::SUM_W-1:0]         mean;
  logic [63:0]                        ex2, msq;
  logic [MW-1:0]                      macc;

  // Log squaring step.
  logic [63:0] m_sq;
  logic [32:0] m_sh;
  assign m_sq = 64'(m) * 64'(m);
  assign m_sh = m_sq[63:31];

  // Log2 magnitude and conversion to natural log.
  logic [clrv_pkg::MAG_W-1:0]    mag, lnmag;
  logic [clrv_pkg::MAG_W+27:0]   ln_prod;
  logic                          ln_neg;
  assign ln_neg = (k < 5'd16);
  always_comb begin
    if (ln_neg) begin
      mag = (clrv_pkg::MAG_W'(5'd16 - k) << LFB) - clrv_pkg::MAG_W'(frac);
    end else begin
      mag = (clrv_pkg::MAG_W'(k - 5'd16) << LFB) + clrv_pkg::MAG_W'(frac);
    end
  end
  assign ln_prod = (clrv_pkg::MAG_W+28)'(mag) * (clrv_pkg::MAG_W+28)'(clrv_pkg::LN2_Q28)
                 + ((clrv_pkg::MAG_W+28)'(1) << 27);
  assign lnmag   = clrv_pkg::MAG_W'(ln_prod >> 28);

  // Return and its rounded square.
  logic signed [clrv_pkg::LNP_W-1:0] r_diff, r_abs;
  logic [clrv_pkg::RMAG_W-1:0]       r_mag;
  logic [clrv_pkg::SQP_W-1:0]        sq_rnd;
  assign r_diff = lnp - prev_log;
  assign r_abs  = r_diff[clrv_pkg::LNP_W-1] ? -r_diff : r_diff;
  assign r_mag  = r_abs[clrv_pkg::RMAG_W-1:0];
  assign sq_rnd = clrv_pkg::SQP_W'(clrv_pkg::SQP_W'(r_mag) * clrv_pkg::SQP_W'(r_mag))
                + clrv_pkg::SQ_HALF;

  // Saturating accumulation.
  logic [clrv_pkg::SUM_W:0] s_new;
  logic [64:0]              q_new;
  assign s_new = {rsum[clrv_pkg::SUM_W-1], rsum}
               + (clrv_pkg::SUM_W+1)'(r_reg);
  assign q_new = {1'b0, sqsum} + {1'b0, sq_reg};

  // Divider operands.
  logic [clrv_pkg::SUM_W-1:0] smag;
  logic                       div_start;
  logic [63:0]                div_dividend, div_q;
  logic                       div_done;
  assign smag         = rsum[clrv_pkg::SUM_W-1] ? clrv_pkg::SUM_W'(-rsum)
                                                : clrv_pkg::SUM_W'(rsum);
  assign div_start    = (cmd == clrv_pkg::CMD_DIV_MEAN) || (cmd == clrv_pkg::CMD_DIV_EX2);
  assign div_dividend = (cmd == clrv_pkg::CMD_DIV_MEAN) ? 64'(smag) : sqsum;

  clrv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  // Partial products of mean squared.
  logic [HW-1:0]   mlo, mhi;
  logic [2*HW-1:0] pp;
  assign mlo = mean[HW-1:0];
  assign mhi = mean[2*HW-1:HW];
  always_comb begin
    unique case (cmd)
      clrv_pkg::CMD_MSQ_LO:  pp = (2*HW)'(mlo) * (2*HW)'(mlo);
      clrv_pkg::CMD_MSQ_MID: pp = (2*HW)'(mlo) * (2*HW)'(mhi);
      default:               pp = (2*HW)'(mhi) * (2*HW)'(mhi);
    endcase
  end

  // Final variance with clamping.
  logic [63:0] var_diff;
  logic [40:0] var_val;
  assign var_diff = (ex2 > msq) ? ex2 - msq : 64'd0;
  assign var_val  = (var_diff > 64'(clrv_pkg::VAR_MAX)) ? clrv_pkg::VAR_MAX
                                                        : var_diff[40:0];

  assign status.norm_done  = m[31];
  assign status.last       = last_l;
  assign status.count_zero = (count == '0);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || out_ready;

  // Output handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == clrv_pkg::CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Accumulated state, cleared by reset and after each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_present <= 1'b0;
      prev_price   <= '0;
      prev_log     <= '0;
      count        <= '0;
      rsum         <= '0;
      sqsum        <= '0;
      ovf          <= 1'b0;
    end else begin
      unique case (cmd)
        clrv_pkg::CMD_ACC: begin
          if (qual) begin
            if (count >= CW'(clrv_pkg::MAX_RETURNS)) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
              if (s_new[clrv_pkg::SUM_W] != s_new[clrv_pkg::SUM_W-1]) begin
                rsum <= s_new[clrv_pkg::SUM_W]
                      ? {1'b1, {(clrv_pkg::SUM_W-1){1'b0}}}
                      : {1'b0, {(clrv_pkg::SUM_W-1){1'b1}}};
              end else begin
                rsum <= s_new[clrv_pkg::SUM_W-1:0];
              end
              sqsum <= q_new[64] ? 64'hFFFF_FFFF_FFFF_FFFF : q_new[63:0];
            end
          end
          prev_price   <= price_l;
          prev_log     <= lnp;
          prev_present <= 1'b1;
        end
        clrv_pkg::CMD_EMIT: begin
          prev_present <= 1'b0;
          prev_price   <= '0;
          prev_log     <= '0;
          count        <= '0;
          rsum         <= '0;
          sqsum        <= '0;
          ovf          <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of one item and of the final computation.
  always_ff @(posedge clk) begin
    unique case (cmd)
      clrv_pkg::CMD_LOAD: begin
        m       <= (in_price == 32'd0) ? 32'd1 : in_price;
        k       <= 5'd31;
        price_l <= in_price;
        start_l <= in_start;
        last_l  <= in_last;
      end
      clrv_pkg::CMD_NORM: begin
        if (!m[31]) begin
          m <= {m[30:0], 1'b0};
          k <= k - 5'd1;
        end
      end
      clrv_pkg::CMD_LOG: begin
        frac <= {frac[LFB-2:0], m_sh[32]};
        m    <= m_sh[32] ? m_sh[32:1] : m_sh[31:0];
      end
      clrv_pkg::CMD_LN: begin
        lnp <= ln_neg ? -$signed(clrv_pkg::LNP_W'(lnmag)) : $signed(clrv_pkg::LNP_W'(lnmag));
      end
      clrv_pkg::CMD_SQ: begin
        r_reg  <= r_diff;
        sq_reg <= 64'(sq_rnd >> clrv_pkg::SQ_SHIFT);
        qual   <= !start_l && prev_present && (prev_price > threshold);
      end
      clrv_pkg::CMD_TAKE_MEAN: mean <= div_q[clrv_pkg::SUM_W-1:0];
      clrv_pkg::CMD_TAKE_EX2:  ex2  <= div_q;
      clrv_pkg::CMD_MSQ_LO:    macc <= MW'(pp);
      clrv_pkg::CMD_MSQ_MID:   macc <= macc + (MW'(pp) << (HW + 1));
      clrv_pkg::CMD_MSQ_HI:    macc <= macc + (MW'(pp) << (2 * HW));
      clrv_pkg::CMD_MSQ_RND:   msq  <= 64'((macc + clrv_pkg::MSQ_HALF) >> clrv_pkg::SQ_SHIFT);
      clrv_pkg::CMD_EMIT: begin
        out_variance <= (count == '0) ? 41'd0 : var_val;
        out_used     <= 23'(count);
        out_none     <= (count == '0);
        out_ovf      <= ovf;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/clrv_ctrl.sv @@
// Controller state machine that sequences the datapath for each item.
// Depends on clrv_pkg.
module clrv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  clrv_pkg::status_t status,
  output clrv_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LOG, S_LN, S_SQ, S_ACC, S_FIN, S_WAIT_MEAN,
    S_DIV_EX2, S_WAIT_EX2, S_MSQ_LO, S_MSQ_MID, S_MSQ_HI, S_MSQ_RND, S_EMIT
  } state_t;

  state_t                      state;
  logic [clrv_pkg::IT_W-1:0]   iter;

  assign in_ready = (state == S_IDLE);

  // Command for the current state.
  always_comb begin
    unique case (state)
      S_IDLE:      cmd = in_valid ? clrv_pkg::CMD_LOAD : clrv_pkg::CMD_NONE;
      S_NORM:      cmd = clrv_pkg::CMD_NORM;
      S_LOG:       cmd = clrv_pkg::CMD_LOG;
      S_LN:        cmd = clrv_pkg::CMD_LN;
      S_SQ:        cmd = clrv_pkg::CMD_SQ;
      S_ACC:       cmd = clrv_pkg::CMD_ACC;
      S_FIN:       cmd = status.count_zero ? clrv_pkg::CMD_NONE : clrv_pkg::CMD_DIV_MEAN;
      S_WAIT_MEAN: cmd = status.div_done ? clrv_pkg::CMD_TAKE_MEAN : clrv_pkg::CMD_NONE;
      S_DIV_EX2:   cmd = clrv_pkg::CMD_DIV_EX2;
      S_WAIT_EX2:  cmd = status.div_done ? clrv_pkg::CMD_TAKE_EX2 : clrv_pkg::CMD_NONE;
      S_MSQ_LO:    cmd = clrv_pkg::CMD_MSQ_LO;
      S_MSQ_MID:   cmd = clrv_pkg::CMD_MSQ_MID;
      S_MSQ_HI:    cmd = clrv_pkg::CMD_MSQ_HI;
      S_MSQ_RND:   cmd = clrv_pkg::CMD_MSQ_RND;
      S_EMIT:      cmd = status.out_free ? clrv_pkg::CMD_EMIT : clrv_pkg::CMD_NONE;
      default:     cmd = clrv_pkg::CMD_NONE;
    endcase
  end

  // State register and squaring counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_NORM;
        S_NORM: begin
          if (status.norm_done) begin
            state <= S_LOG;
            iter  <= '0;
          end
        end
        S_LOG: begin
          iter <= iter + clrv_pkg::IT_W'(1);
          if (iter == clrv_pkg::IT_W'(clrv_pkg::LOG_FRAC_BITS - 1)) state <= S_LN;
        end
        S_LN:  state <= S_SQ;
        S_SQ:  state <= S_ACC;
        S_ACC: state <= status.last ? S_FIN : S_IDLE;
        S_FIN: state <= status.count_zero ? S_EMIT : S_WAIT_MEAN;
        S_WAIT_MEAN: if (status.div_done) state <= S_DIV_EX2;
        S_DIV_EX2:   state <= S_WAIT_EX2;
        S_WAIT_EX2:  if (status.div_done) state <= S_MSQ_LO;
        S_MSQ_LO:    state <= S_MSQ_MID;
        S_MSQ_MID:   state <= S_MSQ_HI;
        S_MSQ_HI:    state <= S_MSQ_RND;
        S_MSQ_RND:   state <= S_EMIT;
        S_EMIT:      if (status.out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/conditional_log_return_variance.sv @@
// Conditional realized variance of log returns over a stream of Q16.16 prices.
// One item is taken at a time. The price is normalized one bit a cycle and
// its log2 fraction comes from one squaring per cycle on a 32x32 multiplier.
// The sample that closes a data set adds, when any return was counted, two
// bit-serial divisions and the mean-square steps that form the result.
// The result waits in an output register, so the next sample is taken while
// it is still pending. The threshold register sits at byte address 0.
// Depends on clrv_pkg, clrv_in_if, clrv_out_if, clrv_ctrl and clrv_dp.
module conditional_log_return_variance (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  clrv_in_if.sink      in_ch,
  clrv_out_if.source   out_ch
);

  logic [31:0]        threshold;
  clrv_pkg::cmd_t     cmd;
  clrv_pkg::status_t  status;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == clrv_pkg::REG_THRESHOLD) ? threshold : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= clrv_pkg::THR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == clrv_pkg::REG_THRESHOLD)) begin
      threshold <= pwdata;
    end
  end

  clrv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  clrv_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .threshold    (threshold),
    .in_price     (in_ch.price),
    .in_start     (in_ch.path_start),
    .in_last      (in_ch.last_sample),
    .status       (status),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_variance (out_ch.variance),
    .out_used     (out_ch.returns_used),
    .out_none     (out_ch.no_returns),
    .out_ovf      (out_ch.count_overflow)
  );

endmodule

@@ tb/tb_conditional_log_return_variance.sv @@
// Self-checking testbench for conditional_log_return_variance: drives price samples
// and threshold writes, predicts each variance result and compares it at the output.
// Depends on clrv_pkg, clrv_in_if, clrv_out_if and the block under test.
`timescale 1ns / 1ps

module tb_conditional_log_return_variance;

  // One result item of the block.
  typedef struct packed {
    logic [40:0] variance;
    logic [22:0] returns_used;
    logic        no_returns;
    logic        count_overflow;
  } var_result_t;

  // Register word that the block does not decode.
  localparam logic REG_UNUSED = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;
  localparam int   SETTLE_CYCLES = 250;
  localparam int   HOLD_CYCLES = 2000;

  // Predicts the variance results and checks them in order.
  class variance_scoreboard;
    bit [31:0]   threshold;
    bit [31:0]   last_price;
    longint      last_log;
    bit          have_last;
    int unsigned ret_count;
    longint      ret_sum;
    bit [63:0]   sq_sum;
    bit          dropped;
    var_result_t expected_q[$];
    int          mismatches;

    function void clear_paths();
      last_price = 0;
      last_log = 0;
      have_last = 0;
      ret_count = 0;
      ret_sum = 0;
      sq_sum = 0;
      dropped = 0;
    endfunction

    function void reset_all();
      threshold = clrv_pkg::THR_RESET;
      clear_paths();
    endfunction

    // Product shifted right by s with round half up, low 64 bits kept.
    function bit [63:0] mul_round(bit [63:0] a, bit [63:0] b, int s);
      bit [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      if (s == 0) return prod[63:0];
      prod = prod + (128'd1 << (s - 1));
      return 64'(prod >> s);
    endfunction

    // Natural log of a Q16.16 price, signed with LOG_FRAC_BITS fraction bits.
    function longint log_price(bit [31:0] p);
      int        k;
      bit [63:0] m, frac, mag, lnmag;
      if (p == 0) p = 1;
      k = 31;
      while (p[k] == 1'b0) k--;
      m = 64'(p) << (31 - k);
      frac = 0;
      for (int i = 0; i < clrv_pkg::LOG_FRAC_BITS; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      if (k >= 16) mag = (64'(k - 16) << clrv_pkg::LOG_FRAC_BITS) + frac;
      else mag = (64'(16 - k) << clrv_pkg::LOG_FRAC_BITS) - frac;
      lnmag = (mag * 64'h0B17217F + (64'd1 << 27)) >> 28;
      return (k >= 16) ? longint'(lnmag) : -longint'(lnmag);
    endfunction

    function void add_return(longint r);
      longint    s;
      bit [63:0] mag, sq;
      longint    sum_max;
      sum_max = (longint'(1) << 51) - 1;
      mag = (r < 0) ? -r : r;
      sq = mul_round(mag, mag, clrv_pkg::SQ_SHIFT);
      if (ret_count >= clrv_pkg::MAX_RETURNS) begin
        dropped = 1;
        return;
      end
      ret_count++;
      s = ret_sum + r;
      if (s > sum_max) s = sum_max;
      if (s < -sum_max - 1) s = -sum_max - 1;
      ret_sum = s;
      sq_sum = (sq_sum + sq < sq_sum) ? '1 : sq_sum + sq;
    endfunction

    // Notes one accepted sample and queues the result it closes, if any.
    function void note_sample(bit [31:0] price, bit start, bit last);
      longint      lnp;
      var_result_t res;
      bit [63:0]   n, smag, mean, msq, ex2, v;
      lnp = log_price(price);
      if (!start && have_last && last_price > threshold) add_return(lnp - last_log);
      last_price = price;
      last_log = lnp;
      have_last = 1;
      if (!last) return;
      res = '0;
      if (ret_count == 0) begin
        res.no_returns = 1;
      end else begin
        n = ret_count;
        smag = (ret_sum < 0) ? -ret_sum : ret_sum;
        mean = smag / n;
        msq = mul_round(mean, mean, clrv_pkg::SQ_SHIFT);
        ex2 = sq_sum / n;
        v = (ex2 > msq) ? ex2 - msq : 0;
        res.variance = (v > 64'(clrv_pkg::VAR_MAX)) ? clrv_pkg::VAR_MAX : v[40:0];
      end
      res.returns_used = ret_count[22:0];
      res.count_overflow = dropped;
      expected_q.insert(expected_q.size(), res);
      clear_paths();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compares one result item with the oldest expectation.
    function void check_result(var_result_t got);
      var_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.variance !== exp_r.variance)
        report($sformatf("variance exp %0d got %0d", exp_r.variance, got.variance));
      if (got.returns_used !== exp_r.returns_used)
        report($sformatf("returns_used exp %0d got %0d", exp_r.returns_used,
                         got.returns_used));
      if (got.no_returns !== exp_r.no_returns)
        report($sformatf("no_returns exp %0b got %0b", exp_r.no_returns, got.no_returns));
      if (got.count_overflow !== exp_r.count_overflow)
        report($sformatf("count_overflow exp %0b got %0b", exp_r.count_overflow,
                         got.count_overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clrv_in_if  in_ch ();
  clrv_out_if out_ch ();

  conditional_log_return_variance i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  variance_scoreboard sb = new();
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_requests = 0;
  int    hold_served = 0;
  int    hold_left = 0;
  int    cycles = 0;
  bit    [31:0] thr_now = clrv_pkg::THR_RESET;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.price = '0;
    in_ch.path_start = 1'b0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, long hold-offs on request, and checking.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.variance, out_ch.returns_used, out_ch.no_returns,
                       out_ch.count_overflow});
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Writes one register through the APB port.
  task automatic write_reg(logic sel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == clrv_pkg::REG_THRESHOLD) begin
      sb.threshold = value;
      thr_now = value;
    end
  endtask

  // Offers one sample and waits until the block takes it.
  task automatic send_sample(logic [31:0] price, logic start, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    in_ch.path_start <= start;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(price, start, last);
  endtask

  // Pauses input until every expected result is out and the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One data set of short paths as a random walk, with some noise samples.
  task automatic run_data_set();
    int     n;
    longint p;
    bit     start;
    n = $urandom_range(1, 12);
    if ($urandom_range(3) == 0 || thr_now < 32'h0001_0000 || thr_now > 32'hF000_0000)
      p = longint'($urandom()) | 1;
    else
      p = longint'(thr_now) + (longint'(thr_now) >> 3) - longint'($urandom_range(0,
          thr_now >> 2));
    for (int i = 0; i < n; i++) begin
      start = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
      if ($urandom_range(9) == 0) begin
        p = longint'($urandom());
        if ($urandom_range(9) != 0 && p == 0) p = 1;
      end else if ($urandom_range(1)) begin
        p = p + (p >> $urandom_range(2, 10));
      end else begin
        p = p - (p >> $urandom_range(2, 10));
      end
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      if (p < 0) p = 1;
      send_sample(p[31:0], start, i == n - 1);
    end
  endtask

  initial begin
    sb.reset_all();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero price, and the named special cases.
    send_sample(32'h0000_0001, 1'b1, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'h0001_0000, 1'b0, 1'b1);
    // A set with no qualifying return.
    send_sample(32'h0001_0000, 1'b1, 1'b1);
    // Sample without a stored previous one forms no return.
    send_sample(32'h0100_0000, 1'b0, 1'b0);
    send_sample(32'h0120_0000, 1'b0, 1'b0);
    send_sample(32'h0110_0000, 1'b1, 1'b0);
    send_sample(32'h0090_0000, 1'b0, 1'b1);
    // Prices at and around the threshold.
    send_sample(clrv_pkg::THR_RESET, 1'b1, 1'b0);
    send_sample(clrv_pkg::THR_RESET + 1, 1'b0, 1'b0);
    send_sample(clrv_pkg::THR_RESET + 2, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b1);
    drain();
    write_reg(REG_UNUSED, $urandom());
    write_reg(clrv_pkg::REG_THRESHOLD, 32'd0);
    send_sample(32'h0000_0001, 1'b1, 1'b0);
    send_sample(32'h0000_0002, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0000_0001, 1'b0, 1'b1);
    drain();

    // Random phases with different idling and thresholds.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: write_reg(clrv_pkg::REG_THRESHOLD, clrv_pkg::THR_RESET);
        1: write_reg(clrv_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
        2: write_reg(clrv_pkg::REG_THRESHOLD, 32'd0);
        default: write_reg(clrv_pkg::REG_THRESHOLD, $urandom_range(32'h0200_0000));
      endcase
      if (ph == 4) hold_requests++;
      for (int s = 0; s < 20; s++) run_data_set();
      drain();
    end

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
